FILE: rtl/core/affine_transform_inverse_assert.svh
// Assertion macros for the affine transform inverse checker.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef AFFINE_TRANSFORM_INVERSE_ASSERT_SVH
`define AFFINE_TRANSFORM_INVERSE_ASSERT_SVH

// Same-cycle implication.
`define AFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/aff_inv_pkg.sv
// ----------------------------------------------------------------------------
// aff_inv_pkg
// Shared types and constants of the affine transform inverse.
// ----------------------------------------------------------------------------
package aff_inv_pkg;

  // Row codes of a result
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  // Magnitude widths of cofactor and determinant
  localparam int unsigned CAW = 64;
  localparam int unsigned DAW = 96;

  // Operand selection of cofactor r*3+j: a*b - c*d, input field indices
  localparam logic [3:0] COF_SEL [9][4] = '{
    '{4'd5, 4'd10, 4'd6, 4'd9},
    '{4'd2, 4'd9,  4'd1, 4'd10},
    '{4'd1, 4'd6,  4'd2, 4'd5},
    '{4'd6, 4'd8,  4'd4, 4'd10},
    '{4'd0, 4'd10, 4'd2, 4'd8},
    '{4'd2, 4'd4,  4'd0, 4'd6},
    '{4'd4, 4'd9,  4'd5, 4'd8},
    '{4'd1, 4'd8,  4'd0, 4'd9},
    '{4'd0, 4'd5,  4'd1, 4'd4}
  };

  // One transform after the cofactor and determinant pipeline
  typedef struct packed {
    logic [2:0][2:0][CAW-1:0] cabs;
    logic [2:0][2:0]          csgn;
    logic [DAW-1:0]           dabs;
    logic                     dsgn;
    logic                     sing;
    logic [2:0][31:0]         t;
  } aff_item_t;

  // Row sideband carried alongside the divider
  typedef struct packed {
    logic [1:0]       row;
    logic             sing;
    logic [2:0][31:0] t;
  } aff_sb_t;

endpackage

FILE: rtl/core/aff_front.sv
// ----------------------------------------------------------------------------
// aff_front
// Seven-stage pipeline: cofactors, their magnitudes and the determinant.
// ----------------------------------------------------------------------------
module aff_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   in_valid_i,
  input  logic [11:0][31:0]      m_i,
  output logic                   valid_o,
  output aff_inv_pkg::aff_item_t item_o
);

  logic [6:0] v_q;

  logic signed [63:0] pa_d [9];
  logic signed [63:0] pb_d [9];
  logic [31:0]        mabs_d [3];
  logic [2:0]         msgn_d;

  logic signed [63:0] s1_pa_q [9];
  logic signed [63:0] s1_pb_q [9];
  logic [31:0]        s1_mabs_q [3];
  logic [2:0]         s1_msgn_q;
  logic [2:0][31:0]   s1_t_q;

  logic signed [64:0] s2_c_q [9];
  logic [31:0]        s2_mabs_q [3];
  logic [2:0]         s2_msgn_q;
  logic [2:0][31:0]   s2_t_q;

  logic [63:0]        s3_cabs_q [9];
  logic [8:0]         s3_csgn_q;
  logic [31:0]        s3_mabs_q [3];
  logic [2:0]         s3_msgn_q;
  logic [2:0][31:0]   s3_t_q;

  logic [63:0]        s4_lo_q [3];
  logic [63:0]        s4_hi_q [3];
  logic [2:0]         s4_sg_q;
  logic [63:0]        s4_cabs_q [9];
  logic [8:0]         s4_csgn_q;
  logic [2:0][31:0]   s4_t_q;

  logic signed [96:0] s5_term_q [3];
  logic [63:0]        s5_cabs_q [9];
  logic [8:0]         s5_csgn_q;
  logic [2:0][31:0]   s5_t_q;

  logic signed [96:0] s6_det_q;
  logic [63:0]        s6_cabs_q [9];
  logic [8:0]         s6_csgn_q;
  logic [2:0][31:0]   s6_t_q;

  logic [95:0]        s7_dabs_q;
  logic               s7_dsgn_q;
  logic               s7_sing_q;
  logic [63:0]        s7_cabs_q [9];
  logic [8:0]         s7_csgn_q;
  logic [2:0][31:0]   s7_t_q;

  // Advance the valid bits with the stall enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  // Form the cofactor products and the first-row magnitudes
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pa_d[k] = $signed(m_i[aff_inv_pkg::COF_SEL[k][0]])
              * $signed(m_i[aff_inv_pkg::COF_SEL[k][1]]);
      pb_d[k] = $signed(m_i[aff_inv_pkg::COF_SEL[k][2]])
              * $signed(m_i[aff_inv_pkg::COF_SEL[k][3]]);
    end
    for (int i = 0; i < 3; i++) begin
      msgn_d[i] = m_i[i][31];
      mabs_d[i] = m_i[i][31] ? (32'd0 - m_i[i]) : m_i[i];
    end
  end

  // Stage data; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: products
      for (int k = 0; k < 9; k++) begin
        s1_pa_q[k] <= pa_d[k];
        s1_pb_q[k] <= pb_d[k];
      end
      for (int i = 0; i < 3; i++) s1_mabs_q[i] <= mabs_d[i];
      s1_msgn_q <= msgn_d;
      s1_t_q    <= {m_i[11], m_i[7], m_i[3]};

      // stage 2: cofactor differences
      for (int k = 0; k < 9; k++) s2_c_q[k] <= 65'(s1_pa_q[k]) - 65'(s1_pb_q[k]);
      s2_mabs_q <= s1_mabs_q;
      s2_msgn_q <= s1_msgn_q;
      s2_t_q    <= s1_t_q;

      // stage 3: cofactor magnitudes
      for (int k = 0; k < 9; k++) begin
        s3_csgn_q[k] <= s2_c_q[k][64];
        s3_cabs_q[k] <= s2_c_q[k][64] ? 64'(65'sd0 - s2_c_q[k]) : s2_c_q[k][63:0];
      end
      s3_mabs_q <= s2_mabs_q;
      s3_msgn_q <= s2_msgn_q;
      s3_t_q    <= s2_t_q;

      // stage 4: determinant partial products, cut into two 32x32 halves
      for (int i = 0; i < 3; i++) begin
        s4_lo_q[i] <= 64'(s3_cabs_q[3*i][31:0]) * 64'(s3_mabs_q[i]);
        s4_hi_q[i] <= 64'(s3_cabs_q[3*i][63:32]) * 64'(s3_mabs_q[i]);
        s4_sg_q[i] <= s3_csgn_q[3*i] ^ s3_msgn_q[i];
      end
      s4_cabs_q <= s3_cabs_q;
      s4_csgn_q <= s3_csgn_q;
      s4_t_q    <= s3_t_q;

      // stage 5: join halves and apply sign
      for (int i = 0; i < 3; i++) begin
        s5_term_q[i] <= s4_sg_q[i]
          ? (97'sd0 - $signed({1'b0, {s4_hi_q[i], 32'd0} + {32'd0, s4_lo_q[i]}}))
          : $signed({1'b0, {s4_hi_q[i], 32'd0} + {32'd0, s4_lo_q[i]}});
      end
      s5_cabs_q <= s4_cabs_q;
      s5_csgn_q <= s4_csgn_q;
      s5_t_q    <= s4_t_q;

      // stage 6: determinant sum
      s6_det_q  <= s5_term_q[0] + s5_term_q[1] + s5_term_q[2];
      s6_cabs_q <= s5_cabs_q;
      s6_csgn_q <= s5_csgn_q;
      s6_t_q    <= s5_t_q;

      // stage 7: determinant magnitude and zero test
      s7_dsgn_q <= s6_det_q[96];
      s7_dabs_q <= s6_det_q[96] ? 96'(97'sd0 - s6_det_q) : s6_det_q[95:0];
      s7_sing_q <= (s6_det_q == 97'sd0);
      s7_cabs_q <= s6_cabs_q;
      s7_csgn_q <= s6_csgn_q;
      s7_t_q    <= s6_t_q;
    end
  end

  // Pack the finished transform
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        item_o.cabs[r][j] = s7_cabs_q[3*r+j];
        item_o.csgn[r][j] = s7_csgn_q[3*r+j];
      end
    end
    item_o.dabs = s7_dabs_q;
    item_o.dsgn = s7_dsgn_q;
    item_o.sing = s7_sing_q;
    item_o.t    = s7_t_q;
  end

  assign valid_o = v_q[6];

endmodule

FILE: rtl/core/aff_div.sv
// ----------------------------------------------------------------------------
// aff_div
// Three-lane pipelined restoring divider, one quotient bit per stage, with
// round to nearest and saturation to a signed 32-bit coefficient.
// ----------------------------------------------------------------------------
module aff_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aff_inv_pkg::aff_sb_t sb_i,
  input  logic [63:0]          a_i [3],
  input  logic [2:0]           asgn_i,
  input  logic [95:0]          d_i,
  input  logic                 dsgn_i,
  output logic                 valid_o,
  output aff_inv_pkg::aff_sb_t sb_o,
  output logic signed [31:0]   e_o [3],
  output logic [2:0]           ov_o
);

  localparam int unsigned QW   = 2 * FRAC_BITS;
  localparam int unsigned NS   = (QW > 32) ? QW : 32;
  localparam int unsigned NUMW = 64 + QW;

  logic [NS:0]    v_q;
  logic [95:0]    rem_q [NS+1][3];
  logic [NS-1:0]  quo_q [NS+1][3];
  logic [NS-1:0]  nlo_q [NS+1][3];
  logic [2:0]     big_q [NS+1];
  logic [2:0]     neg_q [NS+1];
  logic [95:0]    d_q   [NS+1];
  aff_inv_pkg::aff_sb_t sb_q [NS+1];

  logic [NUMW-1:0] num_d [3];
  logic [95:0]     rin_d [3];

  logic                 vr_q;
  aff_inv_pkg::aff_sb_t sbr_q;
  logic signed [31:0]   e_q [3];
  logic [2:0]           ov_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vr_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[NS-1:0], valid_i};
      vr_q <= v_q[NS];
    end
  end

  // Split the numerator |c| * 2^(2F) into the starting remainder and the
  // bits still to shift in
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = {a_i[k], {QW{1'b0}}};
      rin_d[k] = 96'(num_d[k] >> NS);
    end
  end

  // Stage 0: quotient range check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= rin_d[k];
        quo_q[0][k] <= '0;
        nlo_q[0][k] <= num_d[k][NS-1:0];
        big_q[0][k] <= (rin_d[k] >= d_i);
        neg_q[0][k] <= asgn_i[k] ^ dsgn_i;
      end
      d_q[0]  <= d_i;
      sb_q[0] <= sb_i;
    end
  end

  // One quotient bit per stage
  for (genvar i = 1; i <= NS; i++) begin : g_step
    logic [96:0] r2 [3];
    logic [2:0]  ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {rem_q[i-1][k], nlo_q[i-1][k][NS-1]};
        ge[k] = (r2[k] >= {1'b0, d_q[i-1]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[i][k] <= ge[k] ? 96'(r2[k] - {1'b0, d_q[i-1]}) : r2[k][95:0];
          quo_q[i][k] <= {quo_q[i-1][k][NS-2:0], ge[k]};
          nlo_q[i][k] <= {nlo_q[i-1][k][NS-2:0], 1'b0};
        end
        big_q[i] <= big_q[i-1];
        neg_q[i] <= neg_q[i-1];
        d_q[i]   <= d_q[i-1];
        sb_q[i]  <= sb_q[i-1];
      end
    end
  end

  // Round half up, then sign and saturate
  always_ff @(posedge clk_i) begin
    logic [96:0] r2;
    logic [NS:0] qr;
    logic [63:0] qx;
    logic        sat;
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        r2  = {rem_q[NS][k], 1'b0};
        qr  = {1'b0, quo_q[NS][k]} + {{NS{1'b0}}, (r2 >= {1'b0, d_q[NS]})};
        qx  = 64'(qr);
        sat = big_q[NS][k] ||
              (neg_q[NS][k] ? (qx > 64'h8000_0000) : (qx > 64'h7FFF_FFFF));
        ov_q[k] <= sat;
        if (sat) begin
          e_q[k] <= neg_q[NS][k] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          e_q[k] <= neg_q[NS][k] ? $signed(32'd0 - qx[31:0]) : $signed(qx[31:0]);
        end
      end
      sbr_q <= sb_q[NS];
    end
  end

  assign valid_o = vr_q;
  assign sb_o    = sbr_q;
  assign e_o     = e_q;
  assign ov_o    = ov_q;

endmodule

FILE: rtl/core/aff_row.sv
// ----------------------------------------------------------------------------
// aff_row
// Row buffer, divider lanes and translation stages; issues one inverse row
// per cycle from a held transform while the output is not stalled.
// ----------------------------------------------------------------------------
module aff_row #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  aff_inv_pkg::aff_item_t item_i,
  output logic                   take_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             out_row_o,
  output logic signed [31:0]     out_x_o,
  output logic signed [31:0]     out_y_o,
  output logic signed [31:0]     out_z_o,
  output logic signed [31:0]     out_offset_o,
  output logic                   singular_o,
  output logic                   overflow_o,
  output logic                   last_row_o
);

  localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic en;

  logic                   buf_v_q;
  logic [1:0]             buf_row_q;
  aff_inv_pkg::aff_item_t buf_q;

  logic [2:0][63:0] sel_cabs;
  logic [2:0]       sel_csgn;

  logic                 s0_v_q;
  aff_inv_pkg::aff_sb_t s0_sb_q;
  logic [63:0]          s0_a_q [3];
  logic [2:0]           s0_asgn_q;
  logic [95:0]          s0_d_q;
  logic                 s0_dsgn_q;

  logic                 dv;
  aff_inv_pkg::aff_sb_t dsb;
  logic signed [31:0]   de [3];
  logic [2:0]           dov;

  logic                 m_v_q;
  aff_inv_pkg::aff_sb_t m_sb_q;
  logic signed [31:0]   m_e_q [3];
  logic                 m_ov_q;
  logic signed [63:0]   m_p_q [3];

  logic                 s_v_q;
  aff_inv_pkg::aff_sb_t s_sb_q;
  logic signed [31:0]   s_e_q [3];
  logic                 s_ov_q;
  logic signed [65:0]   s_sum_q;

  logic                 a_v_q;
  aff_inv_pkg::aff_sb_t a_sb_q;
  logic signed [31:0]   a_e_q [3];
  logic                 a_ov_q;
  logic                 a_neg_q;
  logic [63:0]          a_mag_q;

  logic               o_v_q;
  logic [1:0]         o_row_q;
  logic signed [31:0] o_x_q, o_y_q, o_z_q, o_off_q;
  logic               o_sing_q, o_ov_q;

  // Whole row pipeline moves unless the output holds an untaken request
  assign en     = !o_v_q || out_ready_i;
  assign take_o = !buf_v_q || ((buf_row_q == aff_inv_pkg::ROW_Z) && en);

  // Row buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q   <= 1'b0;
      buf_row_q <= aff_inv_pkg::ROW_X;
    end else if (take_o) begin
      buf_v_q   <= in_valid_i;
      buf_row_q <= aff_inv_pkg::ROW_X;
    end else if (en) begin
      buf_row_q <= buf_row_q + 2'd1;
    end
  end

  // Hold the transform for its three rows
  always_ff @(posedge clk_i) begin
    if (take_o) buf_q <= item_i;
  end

  // Pick the cofactors of the current row
  always_comb begin
    case (buf_row_q)
      aff_inv_pkg::ROW_Y: begin
        sel_cabs = buf_q.cabs[1];
        sel_csgn = buf_q.csgn[1];
      end
      aff_inv_pkg::ROW_Z: begin
        sel_cabs = buf_q.cabs[2];
        sel_csgn = buf_q.csgn[2];
      end
      default: begin
        sel_cabs = buf_q.cabs[0];
        sel_csgn = buf_q.csgn[0];
      end
    endcase
  end

  // Valid bits of the row stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      m_v_q  <= 1'b0;
      s_v_q  <= 1'b0;
      a_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      s0_v_q <= buf_v_q;
      m_v_q  <= dv;
      s_v_q  <= m_v_q;
      a_v_q  <= s_v_q;
      o_v_q  <= a_v_q;
    end
  end

  // Issue stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) s0_a_q[k] <= sel_cabs[k];
      s0_asgn_q    <= sel_csgn;
      s0_d_q       <= buf_q.dabs;
      s0_dsgn_q    <= buf_q.dsgn;
      s0_sb_q.row  <= buf_row_q;
      s0_sb_q.sing <= buf_q.sing;
      s0_sb_q.t    <= buf_q.t;
    end
  end

  aff_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .sb_i    (s0_sb_q),
    .a_i     (s0_a_q),
    .asgn_i  (s0_asgn_q),
    .d_i     (s0_d_q),
    .dsgn_i  (s0_dsgn_q),
    .valid_o (dv),
    .sb_o    (dsb),
    .e_o     (de),
    .ov_o    (dov)
  );

  // Translation: products, sum and round; the output register saturates
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) m_p_q[k] <= de[k] * $signed(dsb.t[k]);
      m_e_q   <= de;
      m_ov_q  <= |dov;
      m_sb_q  <= dsb;

      s_sum_q <= 66'(m_p_q[0]) + 66'(m_p_q[1]) + 66'(m_p_q[2]);
      s_e_q   <= m_e_q;
      s_ov_q  <= m_ov_q;
      s_sb_q  <= m_sb_q;

      // offset is minus the sum, so a positive sum gives a negative offset
      a_neg_q <= !s_sum_q[65] && (s_sum_q != 66'sd0);
      a_mag_q <= ((s_sum_q[65] ? 64'(66'sd0 - s_sum_q) : s_sum_q[63:0]) + RND)
                 >> FRAC_BITS;
      a_e_q   <= s_e_q;
      a_ov_q  <= s_ov_q;
      a_sb_q  <= s_sb_q;
    end
  end

  // Output register; a singular transform gives identity rows
  always_ff @(posedge clk_i) begin
    logic sat;
    if (en) begin
      sat = a_neg_q ? (a_mag_q > 64'h8000_0000) : (a_mag_q > 64'h7FFF_FFFF);
      o_row_q  <= a_sb_q.row;
      o_sing_q <= a_sb_q.sing;
      if (a_sb_q.sing) begin
        o_x_q   <= (a_sb_q.row == aff_inv_pkg::ROW_X) ? $signed(ONE) : 32'sd0;
        o_y_q   <= (a_sb_q.row == aff_inv_pkg::ROW_Y) ? $signed(ONE) : 32'sd0;
        o_z_q   <= (a_sb_q.row == aff_inv_pkg::ROW_Z) ? $signed(ONE) : 32'sd0;
        o_off_q <= 32'sd0;
        o_ov_q  <= 1'b0;
      end else begin
        o_x_q  <= a_e_q[0];
        o_y_q  <= a_e_q[1];
        o_z_q  <= a_e_q[2];
        o_ov_q <= a_ov_q || sat;
        if (sat) begin
          o_off_q <= a_neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          o_off_q <= a_neg_q ? $signed(32'd0 - a_mag_q[31:0]) : $signed(a_mag_q[31:0]);
        end
      end
    end
  end

  assign out_valid_o  = o_v_q;
  assign out_row_o    = o_row_q;
  assign out_x_o      = o_x_q;
  assign out_y_o      = o_y_q;
  assign out_z_o      = o_z_q;
  assign out_offset_o = o_off_q;
  assign singular_o   = o_sing_q;
  assign overflow_o   = o_ov_q;
  assign last_row_o   = (o_row_q == aff_inv_pkg::ROW_Z);

endmodule

FILE: rtl/core/affine_transform_inverse.sv
// ----------------------------------------------------------------------------
// affine_transform_inverse
// Rows pass the front pipeline, row buffer, issue stage, divider and translation
// stages in that order; while the output is not stalled, the second and third
// rows follow one a cycle and the divider takes one row a cycle. Throughput is
// set by the single result channel that carries three rows per transform.
// Reset clears the valid bits and the row counter; data registers keep no reset.
// ----------------------------------------------------------------------------
module affine_transform_inverse #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] m_xx_i,
  input  logic signed [31:0] m_xy_i,
  input  logic signed [31:0] m_xz_i,
  input  logic signed [31:0] t_x_i,
  input  logic signed [31:0] m_yx_i,
  input  logic signed [31:0] m_yy_i,
  input  logic signed [31:0] m_yz_i,
  input  logic signed [31:0] t_y_i,
  input  logic signed [31:0] m_zx_i,
  input  logic signed [31:0] m_zy_i,
  input  logic signed [31:0] m_zz_i,
  input  logic signed [31:0] t_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_row_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_offset_o,
  output logic               singular_o,
  output logic               overflow_o,
  output logic               last_row_o
);

  logic [11:0][31:0]      m;
  logic                   front_v;
  logic                   front_en;
  logic                   take;
  aff_inv_pkg::aff_item_t item;

  // Gather the request fields, index 0 first
  assign m = {t_z_i, m_zz_i, m_zy_i, m_zx_i,
              t_y_i, m_yz_i, m_yy_i, m_yx_i,
              t_x_i, m_xz_i, m_xy_i, m_xx_i};

  // Front pipeline moves while its last stage is empty or being taken
  assign front_en   = !front_v || take;
  assign in_ready_o = front_en;

  aff_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .in_valid_i (in_valid_i),
    .m_i        (m),
    .valid_o    (front_v),
    .item_o     (item)
  );

  aff_row #(
    .FRAC_BITS (FRAC_BITS)
  ) u_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (front_v),
    .item_i       (item),
    .take_o       (take),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_row_o    (out_row_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_offset_o (out_offset_o),
    .singular_o   (singular_o),
    .overflow_o   (overflow_o),
    .last_row_o   (last_row_o)
  );

endmodule

FILE: rtl/core/aff_inv_chk.sv
// ----------------------------------------------------------------------------
// aff_inv_chk
// Port-level checker: row order, pending count, singular rows.
// ----------------------------------------------------------------------------
`include "affine_transform_inverse_assert.svh"

module aff_inv_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         out_row_o,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_offset_o,
  input logic               singular_o,
  input logic               overflow_o
);

  logic       in_acc, out_acc;
  logic [7:0] pend_q, pend_d;
  logic [1:0] exp_row_q, exp_row_d;
  logic       sing_q, sing_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track rows owed and the expected row order
  always_comb begin
    pend_d    = pend_q + (in_acc ? 8'd3 : 8'd0) - (out_acc ? 8'd1 : 8'd0);
    exp_row_d = exp_row_q;
    sing_d    = sing_q;
    if (out_acc) begin
      exp_row_d = (exp_row_q == aff_inv_pkg::ROW_Z) ? aff_inv_pkg::ROW_X
                                                    : exp_row_q + 2'd1;
      if (out_row_o == aff_inv_pkg::ROW_X) sing_d = singular_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      exp_row_q <= aff_inv_pkg::ROW_X;
      sing_q    <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      exp_row_q <= exp_row_d;
      sing_q    <= sing_d;
    end
  end

  `AFF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_x_o) && $stable(out_row_o), "stalled result request changed")
  `AFF_ASSERT_IMPL(a_row_order, out_valid_o, out_row_o == exp_row_q, "result rows out of order")
  `AFF_ASSERT_IMPL(a_no_spurious, out_valid_o, pend_q != 8'd0, "result row without a request")
  `AFF_ASSERT_IMPL(a_sing_same, out_valid_o && (out_row_o != aff_inv_pkg::ROW_X), singular_o == sing_q, "singular flag differs within one transform")
  `AFF_ASSERT_IMPL(a_sing_clean, out_valid_o && singular_o, !overflow_o && (out_offset_o == 32'sd0), "singular row with overflow or offset")

endmodule

bind affine_transform_inverse aff_inv_chk u_aff_inv_chk (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the affine transform inverse. Directed transforms
// from a stimulus table, then random ones, go on the request channel; each
// accepted one yields three expected rows, typed in the table or else from an
// exact wide-integer model. Both channels idle at random, the receiver holds
// off once for a long stretch, and every result row is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAC = 16;
  localparam int          RUN_LIMIT = 200000;
  localparam int          N_RANDOM = 80;
  localparam int          HOLD_CYCLES = 400;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  // Twelve fields of one transform: xx xy xz tx yx yy yz ty zx zy zz tz
  typedef struct packed {
    logic [11:0][31:0] m;
  } xform_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] off;
    logic               sing;
    logic               ov;
    logic               last;
  } inv_row_t;

  typedef struct {
    xform_t             xf;
    bit                 typed;
    logic signed [31:0] diag;
    logic signed [31:0] off [3];
    bit                 sing;
    bit                 ov;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] m_xx_i = '0, m_xy_i = '0, m_xz_i = '0, t_x_i = '0;
  logic signed [31:0] m_yx_i = '0, m_yy_i = '0, m_yz_i = '0, t_y_i = '0;
  logic signed [31:0] m_zx_i = '0, m_zy_i = '0, m_zz_i = '0, t_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] out_row_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o, out_offset_o;
  logic singular_o, overflow_o, last_row_o;

  inv_row_t  pending_rows [$];
  stim_row_t directed [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        rows_seen = 0;
  bit        quiet = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;

  affine_transform_inverse #(.FRAC_BITS(FRAC)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Saturate a signed magnitude to 32 bits
  function automatic logic signed [31:0] clamp32(bit neg, logic [255:0] mag,
                                                 ref bit ov);
    if (!neg) begin
      if (mag > 256'h7FFF_FFFF) begin
        ov = 1'b1;
        return SMAX;
      end
      return mag[31:0];
    end
    if (mag > 256'h8000_0000) begin
      ov = 1'b1;
      return SMIN;
    end
    return -mag[31:0];
  endfunction

  // Exact inverse of one transform, pushed as three rows
  task automatic push_inverse(input xform_t xf);
    logic signed [255:0] v [12];
    logic signed [255:0] c [3][3];
    logic signed [255:0] det, s;
    logic [255:0] ca, da, q, mag;
    logic signed [31:0] e [3];
    bit ov, sing;
    inv_row_t r;
    for (int k = 0; k < 12; k++) v[k] = $signed(xf.m[k]);
    c[0][0] = v[5] * v[10] - v[6] * v[9];
    c[1][0] = v[6] * v[8] - v[4] * v[10];
    c[2][0] = v[4] * v[9] - v[5] * v[8];
    c[0][1] = v[2] * v[9] - v[1] * v[10];
    c[1][1] = v[0] * v[10] - v[2] * v[8];
    c[2][1] = v[1] * v[8] - v[0] * v[9];
    c[0][2] = v[1] * v[6] - v[2] * v[5];
    c[1][2] = v[2] * v[4] - v[0] * v[6];
    c[2][2] = v[0] * v[5] - v[1] * v[4];
    det = c[0][0] * v[0] + c[1][0] * v[1] + c[2][0] * v[2];
    sing = (det == 0);
    da = (det < 0) ? -det : det;
    for (int i = 0; i < 3; i++) begin
      ov = 1'b0;
      if (sing) begin
        for (int j = 0; j < 3; j++) e[j] = (i == j) ? ONE : '0;
        r.off = '0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          ca = (c[i][j] < 0) ? -c[i][j] : c[i][j];
          // round half up: floor((2n + d) / 2d)
          q = (((ca << (2 * FRAC)) << 1) + da) / (da << 1);
          e[j] = clamp32((c[i][j] < 0) != (det < 0), q, ov);
        end
        s = $signed(e[0]) * v[3] + $signed(e[1]) * v[7] + $signed(e[2]) * v[11];
        mag = (((s < 0) ? -s : s) + (256'd1 << (FRAC - 1))) >> FRAC;
        r.off = clamp32(s > 0, mag, ov);
      end
      r.row = 2'(i);
      r.x = e[0];
      r.y = e[1];
      r.z = e[2];
      r.sing = sing;
      r.ov = ov;
      r.last = (i == 2);
      pending_rows.push_back(r);
    end
  endtask

  // Push rows read straight off a diagonal transform
  task automatic push_typed(input stim_row_t st);
    inv_row_t r;
    for (int i = 0; i < 3; i++) begin
      r.row = 2'(i);
      r.x = (i == 0) ? st.diag : '0;
      r.y = (i == 1) ? st.diag : '0;
      r.z = (i == 2) ? st.diag : '0;
      r.off = st.off[i];
      r.sing = st.sing;
      r.ov = st.ov;
      r.last = (i == 2);
      pending_rows.push_back(r);
    end
  endtask

  function automatic xform_t diag_xf(logic signed [31:0] d, logic signed [31:0] tx,
                                     logic signed [31:0] ty, logic signed [31:0] tz);
    xform_t xf;
    xf.m = '0;
    xf.m[0] = d;
    xf.m[5] = d;
    xf.m[10] = d;
    xf.m[3] = tx;
    xf.m[7] = ty;
    xf.m[11] = tz;
    return xf;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(5))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return 32'd1;
      4: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly near-identity transforms, then full range, singular and extremes
  function automatic xform_t rand_xf();
    xform_t xf;
    int mode;
    mode = $urandom_range(99);
    for (int k = 0; k < 12; k++) begin
      if (mode < 55) begin
        if (k == 3 || k == 7 || k == 11) xf.m[k] = $urandom;
        else if (k == 0 || k == 5 || k == 10)
          xf.m[k] = ONE + $signed($urandom_range(32'h8000)) - 32'sh4000;
        else xf.m[k] = $signed($urandom_range(32'h8000)) - 32'sh4000;
      end else if (mode < 80) begin
        xf.m[k] = $urandom;
      end else if (mode < 90) begin
        xf.m[k] = (k >= 8) ? xf.m[k - 8] : $urandom;
      end else begin
        xf.m[k] = pick_extreme();
      end
    end
    return xf;
  endfunction

  // Offer one request and hold it until taken
  task automatic send(input xform_t xf);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {m_xx_i, m_xy_i, m_xz_i, t_x_i} <= {xf.m[0], xf.m[1], xf.m[2], xf.m[3]};
    {m_yx_i, m_yy_i, m_yz_i, t_y_i} <= {xf.m[4], xf.m[5], xf.m[6], xf.m[7]};
    {m_zx_i, m_zy_i, m_zz_i, t_z_i} <= {xf.m[8], xf.m[9], xf.m[10], xf.m[11]};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic build_table();
    stim_row_t st;
    xform_t xf;
    // zero transform: singular, identity out
    st = '{xf: '0, typed: 1, diag: ONE, off: '{0, 0, 0}, sing: 1, ov: 0};
    directed.push_back(st);
    st = '{xf: diag_xf(ONE, 0, 0, 0), typed: 1, diag: ONE, off: '{0, 0, 0},
           sing: 0, ov: 0};
    directed.push_back(st);
    st = '{xf: diag_xf(ONE, ONE, 2 * ONE, -3 * ONE), typed: 1, diag: ONE,
           off: '{-ONE, -2 * ONE, 3 * ONE}, sing: 0, ov: 0};
    directed.push_back(st);
    st = '{xf: diag_xf(2 * ONE, 0, 0, 0), typed: 1, diag: 32'sh8000,
           off: '{0, 0, 0}, sing: 0, ov: 0};
    directed.push_back(st);
    // smallest scale: inverse saturates
    st = '{xf: diag_xf(32'sd1, 0, 0, 0), typed: 1, diag: SMAX, off: '{0, 0, 0},
           sing: 0, ov: 1};
    directed.push_back(st);
    // most negative translation: negated offset saturates
    st = '{xf: diag_xf(ONE, SMIN, SMIN, SMIN), typed: 1, diag: ONE,
           off: '{SMAX, SMAX, SMAX}, sing: 0, ov: 1};
    directed.push_back(st);
    st = '{xf: diag_xf(ONE, SMAX, SMAX, SMAX), typed: 1, diag: ONE,
           off: '{-SMAX, -SMAX, -SMAX}, sing: 0, ov: 0};
    directed.push_back(st);
    // predicted rows: extremes, negative determinant, rounding ties
    st.typed = 0;
    xf.m = {12{SMAX}};
    st.xf = xf;
    directed.push_back(st);
    xf.m = {12{SMIN}};
    st.xf = xf;
    directed.push_back(st);
    st.xf = diag_xf(SMIN, SMAX, SMIN, 1);
    directed.push_back(st);
    st.xf = diag_xf(SMAX, -1, 1, SMIN);
    directed.push_back(st);
    st.xf = diag_xf(-ONE, 5, -7, 32'sh8000);
    st.xf.m[1] = 32'sh4000;
    directed.push_back(st);
    st.xf = diag_xf(3 * ONE, 1, 1, 1);
    directed.push_back(st);
    st.xf = diag_xf(32'sd3, -1, 1, -1);
    st.xf.m[9] = SMIN;
    directed.push_back(st);
    for (int k = 0; k < 6; k++) begin
      st.xf = rand_xf();
      for (int j = 0; j < 12; j++) st.xf.m[j] = (k[0] ^ j[0]) ? SMAX : SMIN;
      if (k >= 2) st.xf.m[k] = '0;
      directed.push_back(st);
    end
  endtask

  // Drive the request side
  initial begin
    build_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send(directed[i].xf);
      if (directed[i].typed) push_typed(directed[i]);
      else push_inverse(directed[i].xf);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      xform_t xf;
      quiet = (i >= 45 && i < 70);
      xf = rand_xf();
      send(xf);
      push_inverse(xf);
      if (i == 30) begin
        // drain fully before going on
        in_valid_i <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk_i);
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Drive the result side; hold off once after some rows
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && rows_seen >= 30) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 7);
    end
  end

  // Check every accepted row against the oldest expectation
  always @(posedge clk_i) begin
    inv_row_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_row_o, out_x_o, out_y_o, out_z_o, out_offset_o,
              singular_o, overflow_o, last_row_o};
      rows_seen <= rows_seen + 1;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row: %p", got);
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
